/* rtl/core/roi_pop_pkg.sv */
// Shared types, constants and register codes for the ROI pixel point operations unit.
package roi_pop_pkg;

  localparam int COORD_BITS    = 12;
  localparam int SIZE_BITS     = COORD_BITS + 1;
  localparam int CFG_DATA_BITS = (SIZE_BITS > 9) ? SIZE_BITS : 9;

  localparam logic [7:0]        PIX_MAX     = 8'd255;
  localparam logic [4:0]        GAIN_MIN    = 5'd10;
  localparam logic [4:0]        GAIN_MAX    = 5'd20;
  localparam logic signed [8:0] BRIGHT_MAX  = 9'sd50;
  localparam logic signed [8:0] BRIGHT_MIN  = -9'sd50;
  // floor(x / 10) == (x * 6554) >> 16 for every product of a pixel and a gain
  localparam logic [15:0]       RECIP_TEN   = 16'd6554;
  localparam int                RECIP_SHIFT = 16;

  typedef enum logic [1:0] {
    MODE_BINARIZE = 2'd0,
    MODE_GREY     = 2'd1,
    MODE_BRIGHT   = 2'd2,
    MODE_GAIN     = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_MODE       = 3'd0,
    REG_ROI_ROW    = 3'd1,
    REG_ROI_COL    = 3'd2,
    REG_ROI_HEIGHT = 3'd3,
    REG_ROI_WIDTH  = 3'd4,
    REG_THRESHOLD  = 3'd5,
    REG_OFFSET     = 3'd6,
    REG_GAIN       = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] row;
    logic [COORD_BITS-1:0] col;
    logic [7:0]            in_red;
    logic [7:0]            in_green;
    logic [7:0]            in_blue;
  } pixel_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } result_t;

  typedef struct packed {
    mode_t                 mode;
    logic [COORD_BITS-1:0] roi_row;
    logic [COORD_BITS-1:0] roi_col;
    logic [SIZE_BITS-1:0]  roi_height;
    logic [SIZE_BITS-1:0]  roi_width;
    logic [8:0]            threshold;
    logic signed [8:0]     offset;
    logic [4:0]            gain_tenths;
  } cfg_t;

endpackage

/* rtl/core/roi_pop_cfg.sv */
// Configuration register file of the ROI pixel point operations unit.
module roi_pop_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  roi_pop_pkg::reg_index_t             cfg_index,
  input  logic [roi_pop_pkg::CFG_DATA_BITS-1:0] cfg_data,
  output roi_pop_pkg::cfg_t                   cfg
);
  import roi_pop_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode        <= MODE_BINARIZE;
      cfg.roi_row     <= '0;
      cfg.roi_col     <= '0;
      cfg.roi_height  <= '0;
      cfg.roi_width   <= '0;
      cfg.threshold   <= 9'd128;
      cfg.offset      <= '0;
      cfg.gain_tenths <= 5'd10;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MODE:       cfg.mode        <= mode_t'(cfg_data[1:0]);
        REG_ROI_ROW:    cfg.roi_row     <= cfg_data[COORD_BITS-1:0];
        REG_ROI_COL:    cfg.roi_col     <= cfg_data[COORD_BITS-1:0];
        REG_ROI_HEIGHT: cfg.roi_height  <= cfg_data[SIZE_BITS-1:0];
        REG_ROI_WIDTH:  cfg.roi_width   <= cfg_data[SIZE_BITS-1:0];
        REG_THRESHOLD:  cfg.threshold   <= cfg_data[8:0];
        REG_OFFSET:     cfg.offset      <= $signed(cfg_data[8:0]);
        REG_GAIN:       cfg.gain_tenths <= cfg_data[4:0];
        default:        ;
      endcase
    end
  end

endmodule

/* rtl/core/roi_pop_chan.sv */
// Three-stage arithmetic pipe for one color channel: offset add, gain and mode select.
module roi_pop_chan (
  input  logic              clk,
  input  logic [7:0]        px,
  input  roi_pop_pkg::cfg_t cfg,
  input  logic              below_c,
  output logic [7:0]        value_c
);
  import roi_pop_pkg::*;

  function automatic logic [7:0] clamp_pix(input logic signed [9:0] v);
    logic [7:0] r;
    if (v < 0)                          r = 8'd0;
    else if (v > $signed({2'b00, PIX_MAX})) r = PIX_MAX;
    else                                r = v[7:0];
    return r;
  endfunction

  // stage A: sums and product
  logic [4:0]        gain_lim;
  logic signed [8:0] off_lim;
  logic signed [9:0] grey_sum;
  logic signed [9:0] bright_sum;
  logic [12:0]       prod;

  always_comb begin
    priority if (cfg.gain_tenths < GAIN_MIN) gain_lim = GAIN_MIN;
    else if (cfg.gain_tenths > GAIN_MAX)     gain_lim = GAIN_MAX;
    else                                     gain_lim = cfg.gain_tenths;

    priority if (cfg.offset < BRIGHT_MIN) off_lim = BRIGHT_MIN;
    else if (cfg.offset > BRIGHT_MAX)     off_lim = BRIGHT_MAX;
    else                                  off_lim = cfg.offset;
  end

  assign grey_sum   = $signed({2'b00, px}) + $signed({cfg.offset[8], cfg.offset});
  assign bright_sum = $signed({2'b00, px}) + $signed({off_lim[8], off_lim});
  assign prod       = {5'b0, px} * {8'b0, gain_lim};

  logic signed [9:0] grey_a;
  logic signed [9:0] bright_a;
  logic [12:0]       prod_a;

  always_ff @(posedge clk) begin
    grey_a   <= grey_sum;
    bright_a <= bright_sum;
    prod_a   <= prod;
  end

  // stage B: clamp sums, divide product by ten through the reciprocal
  logic [28:0] scaled;
  assign scaled = {16'b0, prod_a} * {13'b0, RECIP_TEN};

  logic [7:0]  grey_b;
  logic [7:0]  bright_b;
  logic [12:0] quot_b;

  always_ff @(posedge clk) begin
    grey_b   <= clamp_pix(grey_a);
    bright_b <= clamp_pix(bright_a);
    quot_b   <= scaled[RECIP_SHIFT +: 13];
  end

  // stage C: limit gain result and pick by mode
  logic [7:0] gain_c;
  assign gain_c = (quot_b > {5'b0, PIX_MAX}) ? PIX_MAX : quot_b[7:0];

  always_comb begin
    unique case (cfg.mode)
      MODE_BINARIZE: value_c = below_c ? 8'd0 : PIX_MAX;
      MODE_GREY:     value_c = grey_b;
      MODE_BRIGHT:   value_c = bright_b;
      MODE_GAIN:     value_c = gain_c;
      default:       value_c = gain_c;
    endcase
  end

endmodule

/* rtl/core/roi_pixel_point_operations_unit.sv */
// Top level of the ROI pixel point operations unit: region test, channel pipes, output word.
//
//   channel   signals                               handshake
//   pixel in  start, busy, pixel                    taken when start && !busy
//   result    done, result                          one cycle, no back-pressure
//   config    cfg_write, cfg_index, cfg_data        taken when cfg_write
//
// An accepted pixel passes three register stages on its way to its done strobe
// (sum/product, clamp/reciprocal multiply, mode select and region mux); one pixel
// is taken every cycle.
// busy stays low; the pipe never stalls because the receiver cannot hold off.
// Synchronous reset clears the valid bits and loads the register reset values.
module roi_pixel_point_operations_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  roi_pop_pkg::pixel_t                   pixel,
  output logic                                  done,
  output roi_pop_pkg::result_t                  result,
  input  logic                                  cfg_write,
  input  roi_pop_pkg::reg_index_t               cfg_index,
  input  logic [roi_pop_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import roi_pop_pkg::*;

  cfg_t cfg;

  roi_pop_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign busy = 1'b0;

  logic take;
  assign take = start && !busy;

  // stage A: coordinate differences and binarize compare
  logic                  valid_a;
  logic                  row_ge_a;
  logic                  col_ge_a;
  logic [COORD_BITS-1:0] row_diff_a;
  logic [COORD_BITS-1:0] col_diff_a;
  logic                  below_a;
  logic [23:0]           rgb_a;

  always_ff @(posedge clk) begin
    if (rst) valid_a <= 1'b0;
    else     valid_a <= take;
  end

  always_ff @(posedge clk) begin
    row_ge_a   <= pixel.row >= cfg.roi_row;
    col_ge_a   <= pixel.col >= cfg.roi_col;
    row_diff_a <= pixel.row - cfg.roi_row;
    col_diff_a <= pixel.col - cfg.roi_col;
    below_a    <= {1'b0, pixel.in_red} < cfg.threshold;
    rgb_a      <= {pixel.in_red, pixel.in_green, pixel.in_blue};
  end

  // stage B: finish the region test
  logic        valid_b;
  logic        inside_b;
  logic        below_b;
  logic [23:0] rgb_b;

  always_ff @(posedge clk) begin
    if (rst) valid_b <= 1'b0;
    else     valid_b <= valid_a;
  end

  always_ff @(posedge clk) begin
    inside_b <= row_ge_a && ({1'b0, row_diff_a} < cfg.roi_height)
             && col_ge_a && ({1'b0, col_diff_a} < cfg.roi_width);
    below_b  <= below_a;
    rgb_b    <= rgb_a;
  end

  logic [7:0] red_c;
  logic [7:0] green_c;
  logic [7:0] blue_c;

  roi_pop_chan u_red (
    .clk (clk), .px (pixel.in_red),   .cfg (cfg), .below_c (below_b), .value_c (red_c)
  );
  roi_pop_chan u_green (
    .clk (clk), .px (pixel.in_green), .cfg (cfg), .below_c (below_b), .value_c (green_c)
  );
  roi_pop_chan u_blue (
    .clk (clk), .px (pixel.in_blue),  .cfg (cfg), .below_c (below_b), .value_c (blue_c)
  );

  // stage C: register the channel values inside the region, pass the raw word outside it
  logic inside_q;

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= valid_b;
  end

  always_ff @(posedge clk) begin
    inside_q <= inside_b;
    if (inside_b) begin
      result <= '{out_red: red_c, out_green: green_c, out_blue: blue_c};
    end else begin
      result <= '{out_red: rgb_b[23:16], out_green: rgb_b[15:8], out_blue: rgb_b[7:0]};
    end
  end

  a_valid_to_done: assert property (@(posedge clk) disable iff (rst)
    valid_b |=> done) else $error("stage B word did not reach the output");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    !valid_b |=> !done) else $error("done without a word in stage B");

  a_binarize_flat: assert property (@(posedge clk) disable iff (rst)
    (done && inside_q && cfg.mode == MODE_BINARIZE) |->
      (result.out_red == result.out_green && result.out_green == result.out_blue
       && (result.out_red == 8'd0 || result.out_red == PIX_MAX)))
    else $error("binarized word is not flat black or white");

  a_pass_through: assert property (@(posedge clk) disable iff (rst)
    (done && !inside_q) |->
      (result.out_red == $past(pixel.in_red, 3)
       && result.out_green == $past(pixel.in_green, 3)
       && result.out_blue == $past(pixel.in_blue, 3)))
    else $error("pixel outside the region was altered");

endmodule

/* test/roi_pixel_point_operations_unit_test.sv */
// Testbench for the ROI pixel point operations unit: directed table plus random phases, scoreboard.
`timescale 1ns / 1ps

module roi_pixel_point_operations_unit_test;
  import roi_pop_pkg::*;

  typedef struct {
    bit                       is_write;
    reg_index_t               idx;
    logic [CFG_DATA_BITS-1:0] data;
    pixel_t                   px;
    bit                       typed;
    result_t                  want;
  } step_t;

  localparam int PHASES          = 16;
  localparam int ITEMS_PER_PHASE = 25;
  localparam int TAIL_CYCLES     = 8;

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  pixel_t                   pixel;
  logic                     done;
  result_t                  result;
  logic                     cfg_write;
  reg_index_t               cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  // expectation attached to the pixel on the bus, taken when it is accepted
  bit      typed_next;
  result_t typed_val;

  cfg_t    shadow_cfg;
  result_t pending_pixels[$];
  int      error_count;
  step_t   directed_tab[$];

  roi_pixel_point_operations_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .pixel     (pixel),
    .done      (done),
    .result    (result),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("[roi_pixel_point_operations_unit] ERROR");
    $finish;
  end

  function automatic logic [7:0] clamp_pix(int v);
    if (v < 0) return 8'd0;
    if (v > int'(PIX_MAX)) return PIX_MAX;
    return v[7:0];
  endfunction

  function automatic bit in_span(int pos, int first, int count);
    return (pos >= first) && ((pos - first) < count);
  endfunction

  function automatic logic [7:0] point_op(logic [7:0] chan, logic [7:0] red);
    int add;
    int lo;
    int hi;
    int g;
    case (shadow_cfg.mode)
      MODE_BINARIZE: begin
        return (9'(red) < shadow_cfg.threshold) ? 8'd0 : PIX_MAX;
      end
      MODE_GREY: begin
        add = shadow_cfg.offset;
        return clamp_pix(int'(chan) + add);
      end
      MODE_BRIGHT: begin
        add = shadow_cfg.offset;
        lo  = BRIGHT_MIN;
        hi  = BRIGHT_MAX;
        if (add < lo) add = lo;
        if (add > hi) add = hi;
        return clamp_pix(int'(chan) + add);
      end
      default: begin
        g = shadow_cfg.gain_tenths;
        if (g < int'(GAIN_MIN)) g = GAIN_MIN;
        if (g > int'(GAIN_MAX)) g = GAIN_MAX;
        return clamp_pix((int'(chan) * g) / 10);
      end
    endcase
  endfunction

  function automatic result_t predict_pixel(pixel_t p);
    result_t r;
    bit      in_roi;
    in_roi = in_span(p.row, shadow_cfg.roi_row, shadow_cfg.roi_height) &&
             in_span(p.col, shadow_cfg.roi_col, shadow_cfg.roi_width);
    if (in_roi) begin
      r.out_red   = point_op(p.in_red, p.in_red);
      r.out_green = point_op(p.in_green, p.in_red);
      r.out_blue  = point_op(p.in_blue, p.in_red);
    end else begin
      r = '{p.in_red, p.in_green, p.in_blue};
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // scoreboard: push on accept, pop and compare on each result word
  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (done) begin
        if (pending_pixels.size() == 0) begin
          report_mismatch($sformatf("result word with nothing pending: %h", result));
        end else begin
          want = pending_pixels.pop_front();
          if (result.out_red !== want.out_red)
            report_mismatch($sformatf("out_red got %0d want %0d", result.out_red,
                                      want.out_red));
          if (result.out_green !== want.out_green)
            report_mismatch($sformatf("out_green got %0d want %0d", result.out_green,
                                      want.out_green));
          if (result.out_blue !== want.out_blue)
            report_mismatch($sformatf("out_blue got %0d want %0d", result.out_blue,
                                      want.out_blue));
        end
      end
      if (start && !busy)
        pending_pixels.push_back(typed_next ? typed_val : predict_pixel(pixel));
    end
  end

  // hold start high across back-to-back words; lower it only in a gap
  task automatic drive_pixel(pixel_t p, bit typed, result_t want);
    @(negedge clk);
    start      <= 1'b1;
    pixel      <= p;
    typed_next <= typed;
    typed_val  <= want;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle_cycles(int n);
    @(negedge clk);
    start      <= 1'b0;
    typed_next <= 1'b0;
    pixel      <= $bits(pixel_t)'({$urandom, $urandom});
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic wait_for_results();
    idle_cycles(1);
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_MODE:       shadow_cfg.mode        = mode_t'(data[1:0]);
      REG_ROI_ROW:    shadow_cfg.roi_row     = data[COORD_BITS-1:0];
      REG_ROI_COL:    shadow_cfg.roi_col     = data[COORD_BITS-1:0];
      REG_ROI_HEIGHT: shadow_cfg.roi_height  = data[SIZE_BITS-1:0];
      REG_ROI_WIDTH:  shadow_cfg.roi_width   = data[SIZE_BITS-1:0];
      REG_THRESHOLD:  shadow_cfg.threshold   = data[8:0];
      REG_OFFSET:     shadow_cfg.offset      = data[8:0];
      default:        shadow_cfg.gain_tenths = data[4:0];
    endcase
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic step_t wr(reg_index_t idx, int data);
    step_t s;
    s          = '{is_write: 1'b0, idx: REG_MODE, data: '0, px: '0, typed: 1'b0, want: '0};
    s.is_write = 1'b1;
    s.idx      = idx;
    s.data     = data[CFG_DATA_BITS-1:0];
    return s;
  endfunction

  function automatic step_t px(int row, int col, int r, int g, int b);
    step_t s;
    s    = '{is_write: 1'b0, idx: REG_MODE, data: '0, px: '0, typed: 1'b0, want: '0};
    s.px = '{row[COORD_BITS-1:0], col[COORD_BITS-1:0], r[7:0], g[7:0], b[7:0]};
    return s;
  endfunction

  function automatic step_t pxe(int row, int col, int r, int g, int b,
                                int er, int eg, int eb);
    step_t s;
    s       = px(row, col, r, g, b);
    s.typed = 1'b1;
    s.want  = '{er[7:0], eg[7:0], eb[7:0]};
    return s;
  endfunction

  function automatic logic [COORD_BITS-1:0] pick_coord();
    case ($urandom % 4)
      0:       return '0;
      1:       return '1;
      default: return COORD_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] random_reg(reg_index_t idx, int phase);
    logic [CFG_DATA_BITS-1:0] junk;
    logic [8:0]               v9;
    junk = CFG_DATA_BITS'($urandom);
    case (idx)
      REG_MODE: begin
        junk[1:0] = phase[1:0];
      end
      REG_ROI_ROW, REG_ROI_COL: begin
        junk[COORD_BITS-1:0] = pick_coord();
      end
      REG_ROI_HEIGHT, REG_ROI_WIDTH: begin
        case ($urandom % 6)
          0:       junk = '0;
          1:       junk = 13'd4096;
          2:       ;
          default: junk = CFG_DATA_BITS'($urandom_range(1, 40));
        endcase
      end
      REG_THRESHOLD: begin
        case ($urandom % 4)
          0:       junk[8:0] = 9'd0;
          1:       junk[8:0] = 9'd256;
          2:       ;
          default: junk[8:0] = 9'($urandom_range(0, 255));
        endcase
      end
      REG_OFFSET: begin
        case ($urandom % 8)
          0:       v9 = 9'h100;
          1:       v9 = 9'h0FF;
          2:       v9 = 9'h1CE;
          3:       v9 = 9'h032;
          default: v9 = 9'($urandom);
        endcase
        junk[8:0] = v9;
      end
      default: begin
        if ($urandom % 3 != 0) junk[4:0] = 5'($urandom_range(10, 20));
      end
    endcase
    return junk;
  endfunction

  function automatic logic [7:0] pick_chan();
    if ($urandom % 5 == 0) return ($urandom % 2) ? 8'd255 : 8'd0;
    return 8'($urandom);
  endfunction

  // aim most pixels at the region and its one-off edges
  function automatic pixel_t random_pixel();
    pixel_t p;
    int     h;
    int     w;
    int     sh;
    int     sw;
    int     v;
    h = shadow_cfg.roi_height;
    w = shadow_cfg.roi_width;
    p = $bits(pixel_t)'({$urandom, $urandom});
    if (($urandom % 4 != 0) && h != 0 && w != 0) begin
      sh    = (h > 60) ? 60 : h;
      sw    = (w > 60) ? 60 : w;
      v     = int'(shadow_cfg.roi_row) + $urandom_range(0, sh + 1) - 1;
      p.row = v[COORD_BITS-1:0];
      v     = int'(shadow_cfg.roi_col) + $urandom_range(0, sw + 1) - 1;
      p.col = v[COORD_BITS-1:0];
    end
    p.in_red   = pick_chan();
    p.in_green = pick_chan();
    p.in_blue  = pick_chan();
    return p;
  endfunction

  initial begin
    int sent;
    int burst;
    rst        = 1'b1;
    start      = 1'b0;
    pixel      = '0;
    typed_next = 1'b0;
    typed_val  = '0;
    cfg_write  = 1'b0;
    cfg_index  = REG_MODE;
    cfg_data   = '0;
    error_count = 0;
    shadow_cfg = '{mode: MODE_BINARIZE, threshold: 9'd128, gain_tenths: 5'd10,
                   default: '0};

    // empty region after reset: everything passes
    directed_tab.push_back(pxe(0, 0, 0, 0, 0, 0, 0, 0));
    directed_tab.push_back(pxe(4095, 4095, 255, 255, 255, 255, 255, 255));
    directed_tab.push_back(pxe(5, 7, 12, 200, 77, 12, 200, 77));
    // binarize in rows 10..14, columns 20..25
    directed_tab.push_back(wr(REG_ROI_ROW, 10));
    directed_tab.push_back(wr(REG_ROI_COL, 20));
    directed_tab.push_back(wr(REG_ROI_HEIGHT, 5));
    directed_tab.push_back(wr(REG_ROI_WIDTH, 6));
    directed_tab.push_back(pxe(10, 20, 127, 255, 255, 0, 0, 0));
    directed_tab.push_back(pxe(14, 25, 128, 0, 0, 255, 255, 255));
    directed_tab.push_back(pxe(15, 25, 200, 1, 2, 200, 1, 2));
    directed_tab.push_back(pxe(14, 26, 200, 3, 4, 200, 3, 4));
    directed_tab.push_back(pxe(9, 20, 200, 5, 6, 200, 5, 6));
    directed_tab.push_back(pxe(10, 19, 200, 7, 8, 200, 7, 8));
    // threshold above 255 blacks out everything; zero whitens everything
    directed_tab.push_back(wr(REG_THRESHOLD, 256));
    directed_tab.push_back(pxe(12, 22, 255, 1, 2, 0, 0, 0));
    directed_tab.push_back(wr(REG_THRESHOLD, 13'h1E00));
    directed_tab.push_back(pxe(12, 22, 0, 0, 0, 255, 255, 255));
    // add grey at both offset extremes, then -1 written with junk above bit 8
    directed_tab.push_back(wr(REG_MODE, MODE_GREY));
    directed_tab.push_back(wr(REG_OFFSET, 13'h0100));
    directed_tab.push_back(pxe(12, 22, 255, 100, 0, 0, 0, 0));
    directed_tab.push_back(wr(REG_OFFSET, 255));
    directed_tab.push_back(pxe(12, 22, 0, 1, 255, 255, 255, 255));
    directed_tab.push_back(wr(REG_OFFSET, 13'h1FFF));
    directed_tab.push_back(px(12, 22, 0, 1, 255));
    // brightness limits the offset to +/-50
    directed_tab.push_back(wr(REG_MODE, MODE_BRIGHT));
    directed_tab.push_back(wr(REG_OFFSET, 255));
    directed_tab.push_back(pxe(12, 22, 0, 205, 206, 50, 255, 255));
    directed_tab.push_back(wr(REG_OFFSET, 13'h0100));
    directed_tab.push_back(pxe(12, 22, 50, 49, 255, 0, 0, 205));
    // gain: below 10 acts as unity, above 20 as double
    directed_tab.push_back(wr(REG_MODE, 13'h1FFC | MODE_GAIN));
    directed_tab.push_back(wr(REG_GAIN, 0));
    directed_tab.push_back(pxe(12, 22, 0, 128, 255, 0, 128, 255));
    directed_tab.push_back(wr(REG_GAIN, 31));
    directed_tab.push_back(pxe(12, 22, 127, 128, 1, 254, 255, 2));
    directed_tab.push_back(wr(REG_GAIN, 15));
    directed_tab.push_back(px(12, 22, 99, 171, 255));
    // region past the last coordinate must not wrap to zero
    directed_tab.push_back(wr(REG_GAIN, 20));
    directed_tab.push_back(wr(REG_ROI_ROW, 4090));
    directed_tab.push_back(wr(REG_ROI_COL, 4095));
    directed_tab.push_back(wr(REG_ROI_HEIGHT, 4096));
    directed_tab.push_back(wr(REG_ROI_WIDTH, 4096));
    directed_tab.push_back(pxe(4095, 4095, 100, 0, 1, 200, 0, 2));
    directed_tab.push_back(pxe(0, 0, 100, 0, 1, 100, 0, 1));
    directed_tab.push_back(pxe(4089, 4095, 100, 0, 1, 100, 0, 1));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_tab[i]) begin
      if (directed_tab[i].is_write) begin
        wait_for_results();
        write_reg(directed_tab[i].idx, directed_tab[i].data);
        end_writes();
      end else begin
        drive_pixel(directed_tab[i].px, directed_tab[i].typed, directed_tab[i].want);
        if ($urandom % 3 == 0) idle_cycles($urandom_range(1, 4));
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_for_results();
      for (int r = 0; r < 8; r++) begin
        write_reg(reg_index_t'(r), random_reg(reg_index_t'(r), phase));
      end
      end_writes();
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        burst = $urandom_range(1, 16);
        for (int k = 0; k < burst && sent < ITEMS_PER_PHASE; k++) begin
          drive_pixel(random_pixel(), 1'b0, '0);
          sent++;
        end
        case ($urandom % 8)
          0:       wait_for_results();
          1, 2:    ;
          default: idle_cycles($urandom_range(1, 6));
        endcase
      end
    end

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("[roi_pixel_point_operations_unit] OK");
    end else begin
      $display("[roi_pixel_point_operations_unit] ERROR");
    end
    $finish;
  end

endmodule
